// File: design/csvs_pkg.sv
// ----------------------------------------------------------------------------
// CSV splitter package
// Shared types and constants for the CSV field and record splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  typedef logic [15:0] unit_t;

  localparam unit_t QUOTE_UNIT    = 16'h0022;
  localparam unit_t NEWLINE_UNIT  = 16'h000A;
  localparam unit_t SEP_RESET     = 16'd44;

  typedef struct packed {
    logic  end_of_data;
    unit_t char_in;
  } in_item_t;

  typedef struct packed {
    logic  has_char;
    unit_t char_out;
    logic  field_end;
    logic  record_end;
    logic  record_drop;
  } result_t;

  typedef struct packed {
    logic at_field_start;
    logic field_quoted;
    logic field_quote_pending;
    logic line_in_quotes;
    logic line_quote_pending;
    logic record_has_chars;
  } tok_state_t;

  localparam tok_state_t TOK_STATE_RESET = '{
    at_field_start:      1'b1,
    field_quoted:        1'b0,
    field_quote_pending: 1'b0,
    line_in_quotes:      1'b0,
    line_quote_pending:  1'b0,
    record_has_chars:    1'b0
  };

endpackage

// File: design/csvs_in_reg.sv
// ----------------------------------------------------------------------------
// CSV splitter input register
// Holds one input request until the tokeniser takes it.
// ----------------------------------------------------------------------------
module csvs_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csvs_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              hold_valid,
  output csvs_pkg::in_item_t hold_item
);
  import csvs_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: design/csvs_core.sv
// ----------------------------------------------------------------------------
// CSV splitter tokeniser core
// Quote tracking state and the per-unit field and record decisions.
// ----------------------------------------------------------------------------
module csvs_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  csvs_pkg::in_item_t item,
  input  csvs_pkg::unit_t    separator,
  output csvs_pkg::result_t  res
);
  import csvs_pkg::*;

  tok_state_t st_r;
  tok_state_t st_nxt;
  logic       ends_record;
  logic       plain;
  unit_t      c;

  assign c = item.char_in;

  always_comb begin
    st_nxt      = st_r;
    res         = '0;
    ends_record = 1'b0;
    plain       = 1'b0;
    if (item.end_of_data) begin
      res.record_drop = st_r.record_has_chars;
      st_nxt          = TOK_STATE_RESET;
    end else begin
      // Record-level quote tracking decides whether a newline ends the record.
      if (st_r.line_quote_pending) begin
        st_nxt.line_quote_pending = 1'b0;
        if (c != QUOTE_UNIT) begin
          st_nxt.line_in_quotes = 1'b0;
          ends_record           = (c == NEWLINE_UNIT);
        end
      end else if (st_r.line_in_quotes) begin
        if (c == QUOTE_UNIT) begin
          st_nxt.line_quote_pending = 1'b1;
        end
      end else if (c == QUOTE_UNIT) begin
        st_nxt.line_in_quotes = 1'b1;
      end else begin
        ends_record = (c == NEWLINE_UNIT);
      end

      if (ends_record) begin
        res.field_end  = st_r.record_has_chars;
        res.record_end = 1'b1;
        st_nxt         = TOK_STATE_RESET;
      end else begin
        st_nxt.record_has_chars = 1'b1;
        if (st_r.at_field_start) begin
          if (c == QUOTE_UNIT) begin
            st_nxt.field_quoted   = 1'b1;
            st_nxt.at_field_start = 1'b0;
          end else begin
            plain = 1'b1;
          end
        end else if (st_r.field_quote_pending) begin
          st_nxt.field_quote_pending = 1'b0;
          if (c == QUOTE_UNIT) begin
            res.has_char = 1'b1;
            res.char_out = c;
          end else begin
            st_nxt.field_quoted = 1'b0;
            plain               = 1'b1;
          end
        end else if (st_r.field_quoted) begin
          if (c == QUOTE_UNIT) begin
            st_nxt.field_quote_pending = 1'b1;
          end else begin
            res.has_char = 1'b1;
            res.char_out = c;
          end
        end else begin
          plain = 1'b1;
        end

        if (plain) begin
          if (c == separator) begin
            res.field_end              = 1'b1;
            st_nxt.at_field_start      = 1'b1;
            st_nxt.field_quoted        = 1'b0;
            st_nxt.field_quote_pending = 1'b0;
          end else begin
            res.has_char          = 1'b1;
            res.char_out          = c;
            st_nxt.at_field_start = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TOK_STATE_RESET;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: design/csvs_out_reg.sv
// ----------------------------------------------------------------------------
// CSV splitter result register
// Holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module csvs_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              src_valid,
  output logic              load,
  input  csvs_pkg::result_t res_in,
  output logic              out_valid,
  input  logic              out_ready,
  output csvs_pkg::result_t res_out
);
  import csvs_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign load      = src_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// File: design/csv_field_record_splitter_unit.sv
// ----------------------------------------------------------------------------
// CSV field and record splitter
// Splits a stream of 16-bit code units into CSV fields and records.
// ----------------------------------------------------------------------------
// The input channel takes one code unit per request, or an end-of-data mark
// that reports whether an unfinished record is dropped and clears the state.
// Every input request gives exactly one result request on the output channel,
// carrying an optional field character and field-end, record-end and drop
// flags. The configuration channel writes the separator; it is always ready
// and should only be written while no request is in flight.
// A request accepted at one clock edge is held in the input register, decided
// by the tokeniser and loaded into the result register once that register is
// empty or being read: one request per cycle sustained while the receiver
// does not stall, with the quote state updated as each request moves across.
// When the receiver stalls, the result register holds its request, the input
// register fills, and in_ready falls until the output moves again.
// Synchronous reset empties both registers, returns the tokeniser to the start
// of a field and sets the separator back to a comma.
// ----------------------------------------------------------------------------
module csv_field_record_splitter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  csvs_pkg::unit_t    in_char_in,
  input  logic               in_end_of_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_has_char,
  output csvs_pkg::unit_t    out_char_out,
  output logic               out_field_end,
  output logic               out_record_end,
  output logic               out_record_drop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  csvs_pkg::unit_t    cfg_separator
);
  import csvs_pkg::*;

  unit_t    separator_r;
  in_item_t in_item;
  in_item_t hold_item;
  logic     hold_valid;
  logic     load;
  result_t  core_res;
  result_t  res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      separator_r <= SEP_RESET;
    end else if (cfg_valid) begin
      separator_r <= cfg_separator;
    end
  end

  assign in_item.char_in     = in_char_in;
  assign in_item.end_of_data = in_end_of_data;

  csvs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (load),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  csvs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (load),
    .item      (hold_item),
    .separator (separator_r),
    .res       (core_res)
  );

  csvs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (hold_valid),
    .load      (load),
    .res_in    (core_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign out_has_char    = res_out.has_char;
  assign out_char_out    = res_out.char_out;
  assign out_field_end   = res_out.field_end;
  assign out_record_end  = res_out.record_end;
  assign out_record_drop = res_out.record_drop;

endmodule
